// ----- rtl/core/dbd_pkg.sv -----
// shared constants and types for the detection box decoder
package dbd_pkg;

    localparam int ValueW     = 32;
    localparam int EdgeW      = 35;
    localparam int CoordW     = 29;
    localparam int ScoreW     = 17;
    localparam int LabelW     = 8;
    localparam int DimW       = 14;
    localparam int MaxClasses = 128;

    localparam logic [2:0] CfgThreshold  = 3'd0;
    localparam logic [2:0] CfgInvScale   = 3'd1;
    localparam logic [2:0] CfgPadX       = 3'd2;
    localparam logic [2:0] CfgPadY       = 3'd3;
    localparam logic [2:0] CfgImgWidth   = 3'd4;
    localparam logic [2:0] CfgImgHeight  = 3'd5;
    localparam logic [2:0] CfgClassCount = 3'd6;
    localparam logic [2:0] CfgMaxBoxes   = 3'd7;

    typedef struct packed {
        logic mul_load;
        logic out_load;
    } t_stage_ctl;

endpackage

// ----- rtl/core/detection_box_decoder_top.sv -----
// detection box decoder: record accumulation, score test and box output pipeline
//
// Input channel (i_in_valid / o_in_stall) carries one record element per beat:
// cx, cy, w, h and then the class scores; i_frame_start marks a frame's first beat.
// Output channel (o_out_valid / i_out_stall) carries one decoded box per beat.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
// One input beat is taken every cycle while o_in_stall is low. A record's last element
// is taken into the candidate register; from there the box passes the score test and edge
// sums into the edge stage, then the edge multipliers, then the clamp into the output.
// The box stages are elastic, so a held output does not stop the input; the
// input stalls only while a finished candidate cannot move into the edge stage,
// which needs the output and both box stages to be full and the receiver stalling.
// Synchronous reset loads the register defaults, clears the record position,
// box count and frame-full flag and empties all box stages.
// A stalled output beat holds its value until it is taken.
module detection_box_decoder_top
    import dbd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [ValueW-1:0] i_value,
    input  logic                     i_frame_start,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [CoordW-1:0]        o_box_x1,
    output logic [CoordW-1:0]        o_box_y1,
    output logic [CoordW-1:0]        o_box_x2,
    output logic [CoordW-1:0]        o_box_y2,
    output logic [ScoreW-1:0]        o_box_score,
    output logic [LabelW-1:0]        o_box_label,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_index,
    input  logic [31:0]              i_cfg_data
);

    // configuration
    logic [16:0] r_thr;
    logic [31:0] r_inv_scale;
    logic [12:0] r_pad_x, r_pad_y;
    logic [13:0] r_img_w, r_img_h;
    logic [7:0]  r_class_count;
    logic [15:0] r_max_boxes;

    // record state
    logic [7:0]  r_pos, n_pos;
    logic signed [31:0] r_cx, n_cx, r_cy, n_cy, r_w, n_w, r_h, n_h;
    logic [ScoreW-1:0] r_first, n_first, r_best, n_best;
    logic [LabelW-1:0] r_label, n_label;
    logic [16:0] r_cnt, n_cnt;
    logic        r_full, n_full;

    // candidate stage
    logic        r_c_vld;
    logic signed [31:0] r_c_cx, r_c_cy, r_c_w, r_c_h;
    logic [ScoreW-1:0] r_c_first, r_c_best;
    logic [LabelW-1:0] r_c_label;

    // edge stage
    logic        r_e_vld;
    logic signed [EdgeW-1:0] r_e_x1, r_e_y1, r_e_x2, r_e_y2;
    logic [ScoreW-1:0] r_e_score;
    logic [LabelW-1:0] r_e_label;

    // multiply stage and output
    logic        r_m_vld, r_o_vld;
    logic [ScoreW-1:0] r_m_score, r_o_score;
    logic [LabelW-1:0] r_m_label, r_o_label;

    logic       w_acc, w_o_free, w_m_free, w_e_free, w_c_move, w_cap;
    logic [7:0] w_cls, w_last, w_base, w_p;
    logic       w_full_eff, w_is_last;
    logic [ScoreW-1:0] w_s;
    logic [33:0] w_prod;
    logic        w_pass;
    logic signed [EdgeW-1:0] w_cx2, w_cy2, w_wx, w_hx, w_px, w_py;
    t_stage_ctl  w_ctl;

    // elastic box pipeline
    assign w_o_free   = !r_o_vld || !i_out_stall;
    assign w_m_free   = !r_m_vld || w_o_free;
    assign w_e_free   = !r_e_vld || w_m_free;
    assign w_c_move   = r_c_vld && w_e_free;
    assign o_in_stall = r_c_vld && !w_e_free;
    assign w_acc      = i_in_valid && !o_in_stall;

    assign w_ctl.mul_load = w_m_free;
    assign w_ctl.out_load = w_o_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr         <= 17'd16384;
            r_inv_scale   <= 32'd65536;
            r_pad_x       <= '0;
            r_pad_y       <= '0;
            r_img_w       <= 14'd640;
            r_img_h       <= 14'd640;
            r_class_count <= 8'd80;
            r_max_boxes   <= 16'd30000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgThreshold:  r_thr         <= i_cfg_data[16:0];
                CfgInvScale:   r_inv_scale   <= i_cfg_data;
                CfgPadX:       r_pad_x       <= i_cfg_data[12:0];
                CfgPadY:       r_pad_y       <= i_cfg_data[12:0];
                CfgImgWidth:   r_img_w       <= i_cfg_data[13:0];
                CfgImgHeight:  r_img_h       <= i_cfg_data[13:0];
                CfgClassCount: r_class_count <= i_cfg_data[7:0];
                CfgMaxBoxes:   r_max_boxes   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // element position and score capture
    always_comb begin
        if (r_class_count == 8'd0) begin
            w_cls = 8'd1;
        end else if (r_class_count > 8'(MaxClasses)) begin
            w_cls = 8'(MaxClasses);
        end else begin
            w_cls = r_class_count;
        end
        w_last     = w_cls + 8'd3;
        w_base     = i_frame_start ? 8'd0 : r_pos;
        w_p        = (w_base > w_last) ? 8'd0 : w_base;
        w_full_eff = !i_frame_start && r_full;
        w_is_last  = (w_p == w_last);
        if (i_value < 0) begin
            w_s = '0;
        end else if (i_value > 32'sd65536) begin
            w_s = 17'h10000;
        end else begin
            w_s = i_value[ScoreW-1:0];
        end
        w_cap = w_acc && !w_full_eff && w_is_last;
    end

    // score test on the candidate
    assign w_prod = 34'(r_c_first) * 34'(r_c_best);
    assign w_pass = (r_c_first >= r_thr) && (w_prod >= {1'b0, r_thr, 16'b0});

    always_comb begin
        n_pos   = r_pos;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_w     = r_w;
        n_h     = r_h;
        n_first = r_first;
        n_best  = r_best;
        n_label = r_label;
        n_cnt   = r_cnt;
        n_full  = r_full;
        // the box from the previous record counts before this beat
        if (w_c_move && w_pass) begin
            n_cnt = r_cnt + 17'd1;
            if ((r_cnt + 17'd1) > {1'b0, r_max_boxes}) begin
                n_full = 1'b1;
            end
        end
        if (w_acc) begin
            if (i_frame_start) begin
                n_cnt  = '0;
                n_full = 1'b0;
                n_pos  = '0;
            end
            if (!w_full_eff) begin
                case (w_p)
                    8'd0: n_cx = i_value;
                    8'd1: n_cy = i_value;
                    8'd2: n_w  = i_value;
                    8'd3: n_h  = i_value;
                    8'd4: begin
                        n_first = w_s;
                        n_best  = w_s;
                        n_label = '0;
                    end
                    default: begin
                        if (w_s > r_best) begin
                            n_best  = w_s;
                            n_label = w_p - 8'd4;
                        end
                    end
                endcase
                n_pos = w_is_last ? 8'd0 : (w_p + 8'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_first <= '0;
            r_best  <= '0;
            r_label <= '0;
            r_cnt   <= '0;
            r_full  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_w     <= n_w;
            r_h     <= n_h;
            r_first <= n_first;
            r_best  <= n_best;
            r_label <= n_label;
            r_cnt   <= n_cnt;
            r_full  <= n_full;
        end
    end

    // candidate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (!r_c_vld || w_e_free) begin
            r_c_vld <= w_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            r_c_cx    <= n_cx;
            r_c_cy    <= n_cy;
            r_c_w     <= n_w;
            r_c_h     <= n_h;
            r_c_first <= n_first;
            r_c_best  <= n_best;
            r_c_label <= n_label;
        end
    end

    // doubled edges less padding, exact
    assign w_cx2 = {{2{r_c_cx[31]}}, r_c_cx, 1'b0};
    assign w_cy2 = {{2{r_c_cy[31]}}, r_c_cy, 1'b0};
    assign w_wx  = {{3{r_c_w[31]}}, r_c_w};
    assign w_hx  = {{3{r_c_h[31]}}, r_c_h};
    assign w_px  = {5'b0, r_pad_x, 17'b0};
    assign w_py  = {5'b0, r_pad_y, 17'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_e_free) begin
            r_e_vld <= w_c_move && w_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e_free) begin
            r_e_x1    <= w_cx2 - w_wx - w_px;
            r_e_y1    <= w_cy2 - w_hx - w_py;
            r_e_x2    <= w_cx2 + w_wx - w_px;
            r_e_y2    <= w_cy2 + w_hx - w_py;
            r_e_score <= w_prod[32:16];
            r_e_label <= r_c_label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (w_m_free) begin
                r_m_vld <= r_e_vld;
            end
            if (w_o_free) begin
                r_o_vld <= r_m_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_free) begin
            r_m_score <= r_e_score;
            r_m_label <= r_e_label;
        end
        if (w_o_free) begin
            r_o_score <= r_m_score;
            r_o_label <= r_m_label;
        end
    end

    dbd_edge u_edge_x1 (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_twice_edge (r_e_x1),
        .i_inv_scale  (r_inv_scale),
        .i_dim        (r_img_w),
        .o_edge       (o_box_x1)
    );

    dbd_edge u_edge_y1 (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_twice_edge (r_e_y1),
        .i_inv_scale  (r_inv_scale),
        .i_dim        (r_img_h),
        .o_edge       (o_box_y1)
    );

    dbd_edge u_edge_x2 (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_twice_edge (r_e_x2),
        .i_inv_scale  (r_inv_scale),
        .i_dim        (r_img_w),
        .o_edge       (o_box_x2)
    );

    dbd_edge u_edge_y2 (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_twice_edge (r_e_y2),
        .i_inv_scale  (r_inv_scale),
        .i_dim        (r_img_h),
        .o_edge       (o_box_y2)
    );

    assign o_out_valid = r_o_vld;
    assign o_box_score = r_o_score;
    assign o_box_label = r_o_label;

endmodule

// ----- rtl/core/dbd_edge.sv -----
// one box edge: scale by the reciprocal resize ratio and clamp to the image
module dbd_edge
    import dbd_pkg::*;
(
    input  logic                    i_clk,
    input  t_stage_ctl              i_ctl,
    input  logic signed [EdgeW-1:0] i_twice_edge,
    input  logic [31:0]             i_inv_scale,
    input  logic [DimW-1:0]         i_dim,
    output logic [CoordW-1:0]       o_edge
);

    logic        r_pos;
    logic [48:0] r_hi;
    logic [47:0] r_lo;
    logic [CoordW-1:0] r_edge;

    logic [16:0] w_a;
    logic [15:0] w_b;
    logic [49:0] w_sum;
    logic [32:0] w_p;
    logic [12:0] w_dm1;
    logic [CoordW-1:0] w_lim;

    // edge is in units of half a sixteenth-bit pixel and below 2^33 when positive
    assign w_a = i_twice_edge[32:16];
    assign w_b = i_twice_edge[15:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_load) begin
            r_pos <= !i_twice_edge[EdgeW-1] && (i_twice_edge != '0);
            r_hi  <= 49'(w_a) * 49'(i_inv_scale);
            r_lo  <= 48'(w_b) * 48'(i_inv_scale);
        end
    end

    always_comb begin
        w_sum = 50'(r_hi) + 50'(r_lo[47:16]);
        w_p   = w_sum[49:17];
        if (i_dim == '0) begin
            w_dm1 = '0;
        end else if (i_dim > 14'd8192) begin
            w_dm1 = 13'd8191;
        end else begin
            w_dm1 = 13'(i_dim - 14'd1);
        end
        w_lim = {w_dm1, 16'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            if (!r_pos) begin
                r_edge <= '0;
            end else if (w_p < 33'(w_lim)) begin
                r_edge <= w_p[CoordW-1:0];
            end else begin
                r_edge <= w_lim;
            end
        end
    end

    assign o_edge = r_edge;

endmodule
